// ----- rtl/vertex_bbox_normalizer_defines.svh -----
// Assertion macros used by the checker file of the bounding-box normalizer.
`ifndef VERTEX_BBOX_NORMALIZER_DEFINES_SVH
`define VERTEX_BBOX_NORMALIZER_DEFINES_SVH

// Checked only while reset is released.
`define VBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define VBN_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/vbn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package vbn_pkg;

  localparam int COORD_IN_W   = 24;
  localparam int READ_INDEX_W = 12;
  localparam int OUT_W        = 16;
  localparam int RAW_W        = 32;
  localparam int DIV_STEPS    = 16;

  localparam logic [OUT_W-1:0] Q_ONE = 16'd16384;

  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ZERO_EDGE = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic [1:0]                     func;
    logic signed [COORD_IN_W-1:0]   x_in;
    logic signed [COORD_IN_W-1:0]   y_in;
    logic signed [COORD_IN_W-1:0]   z_in;
    logic [READ_INDEX_W-1:0]        read_index;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x_out;
    logic signed [OUT_W-1:0] y_out;
    logic signed [OUT_W-1:0] z_out;
    logic [1:0]              status;
  } out_item_t;

  typedef struct packed {
    logic mid_ld;
    logic d_ld;
    logic step;
  } lane_ctrl_t;

  typedef struct packed {
    logic             neg;
    logic [OUT_W-1:0] mag;
  } lane_res_t;

endpackage

`default_nettype wire

// ----- rtl/vbn_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vbn_lane import vbn_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                         clk,
  input  lane_ctrl_t                   ctrl,
  input  logic signed [COORD_BITS-1:0] coord,
  input  logic signed [COORD_BITS-1:0] lo,
  input  logic signed [COORD_BITS-1:0] hi,
  input  logic [COORD_BITS:0]          edge_len,
  output lane_res_t                    res
);

  logic signed [COORD_BITS:0]   sum;
  logic signed [COORD_BITS-1:0] mid_r;
  logic signed [COORD_BITS:0]   diff;
  logic [COORD_BITS:0]          mag;
  logic [COORD_BITS:0]          rem_r;
  logic [COORD_BITS:0]          rem_nxt;
  logic [COORD_BITS:0]          trial;
  logic                         ge;
  logic                         neg_r;
  logic                         first_r;
  logic [OUT_W-1:0]             quo_r;

  always_comb begin
    sum     = {lo[COORD_BITS-1], lo} + {hi[COORD_BITS-1], hi};
    diff    = {coord[COORD_BITS-1], coord} - {mid_r[COORD_BITS-1], mid_r};
    mag     = diff[COORD_BITS] ? $unsigned(-diff) : $unsigned(diff);
    trial   = first_r ? rem_r : {rem_r[COORD_BITS-1:0], 1'b0};
    ge      = (trial >= edge_len);
    rem_nxt = ge ? (trial - edge_len) : trial;
  end

  // The first step yields the integer bit, the remaining steps the fraction bits.
  always_ff @(posedge clk) begin
    if (ctrl.mid_ld) begin
      mid_r <= sum[COORD_BITS:1];
    end
    if (ctrl.d_ld) begin
      rem_r   <= mag;
      neg_r   <= diff[COORD_BITS];
      first_r <= 1'b1;
      quo_r   <= '0;
    end else if (ctrl.step) begin
      rem_r   <= rem_nxt;
      first_r <= 1'b0;
      quo_r   <= {quo_r[OUT_W-2:0], ge};
    end
  end

  assign res.neg = neg_r;
  assign res.mag = quo_r;

endmodule

`default_nettype wire

// ----- rtl/vbn_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none

module vbn_merge import vbn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  lane_res_t [2:0]   lane_res,
  input  logic              zero_edge,
  input  logic              bad_index,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data
);

  logic             valid_r;
  logic             valid_nxt;
  out_item_t        data_r;
  out_item_t        data_nxt;
  logic [OUT_W-1:0] sat [3];
  logic [OUT_W-1:0] val [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sat[a] = (lane_res[a].mag > Q_ONE) ? Q_ONE : lane_res[a].mag;
      val[a] = lane_res[a].neg ? (~sat[a] + 1'b1) : sat[a];
    end
    data_nxt = '0;
    priority if (bad_index) begin
      data_nxt.status = ST_BAD_INDEX;
    end else if (zero_edge) begin
      data_nxt.status = ST_ZERO_EDGE;
    end else begin
      data_nxt.status = ST_OK;
      data_nxt.x_out  = $signed(val[0]);
      data_nxt.y_out  = $signed(val[1]);
      data_nxt.z_out  = $signed(val[2]);
    end
    can_load  = !valid_r || out_ready;
    valid_nxt = load ? 1'b1 : (valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// ----- rtl/vertex_bbox_normalizer.sv -----
// Clear and append transactions are accepted back to back. A read transaction walks the
// MID, LOAD, DIV and WAIT states; DIV runs the 16-step shift-subtract divider that each of
// the three axis lanes holds, and WAIT holds until the output register can take the result.
// The next transaction is accepted once the read's result has entered the output register.
// Synchronous active-low reset clears the vertex count, the box corners and the output valid;
// the vertex memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module vertex_bbox_normalizer import vbn_pkg::*; #(
  parameter int VERTEX_DEPTH = 4096,
  parameter int COORD_BITS   = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int IDX_W  = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int CNT_W  = $clog2(VERTEX_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > READ_INDEX_W) ? CNT_W : READ_INDEX_W;
  localparam int WORD_W = 3 * COORD_BITS;
  localparam int STEP_W = $clog2(DIV_STEPS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MID  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;

  function automatic logic signed [COORD_BITS-1:0] take_coord(
    input logic signed [COORD_IN_W-1:0] f
  );
    logic [RAW_W-1:0] raw;
    raw = RAW_W'($unsigned(f));
    return raw[COORD_BITS-1:0];
  endfunction

  logic [2:0]                   state_r;
  logic [2:0]                   state_nxt;
  logic [STEP_W-1:0]            step_r;
  logic [STEP_W-1:0]            step_nxt;
  logic [CNT_W-1:0]             count_r;
  logic signed [COORD_BITS-1:0] lo_r [3];
  logic signed [COORD_BITS-1:0] hi_r [3];
  logic signed [COORD_BITS-1:0] in_coord [3];
  logic signed [COORD_BITS:0]   span [3];
  logic [COORD_BITS:0]          edge_max;
  logic [COORD_BITS:0]          edge_r;
  logic                         bad_r;
  logic [CMP_W-1:0]             idx_ext;
  logic [IDX_W-1:0]             rd_addr;
  logic [WORD_W-1:0]            mem [VERTEX_DEPTH];
  logic [WORD_W-1:0]            rdata_r;
  logic                         accept;
  logic                         do_clear;
  logic                         do_append;
  logic                         do_read;
  lane_ctrl_t                   lane_ctrl;
  lane_res_t [2:0]              lane_res;
  logic                         can_load;
  logic                         merge_load;

  always_comb begin
    in_coord[0] = take_coord(in_data.x_in);
    in_coord[1] = take_coord(in_data.y_in);
    in_coord[2] = take_coord(in_data.z_in);
    in_ready    = (state_r == S_IDLE);
    accept      = in_valid && in_ready;
    do_clear    = accept && (in_data.func == FUNC_CLEAR);
    do_append   = accept && (in_data.func == FUNC_APPEND) &&
                  (count_r != CNT_W'(VERTEX_DEPTH));
    do_read     = accept && (in_data.func == FUNC_READ);
    idx_ext     = CMP_W'(in_data.read_index);
    rd_addr     = idx_ext[IDX_W-1:0];
    edge_max    = '0;
    for (int a = 0; a < 3; a++) begin
      span[a] = {hi_r[a][COORD_BITS-1], hi_r[a]} - {lo_r[a][COORD_BITS-1], lo_r[a]};
      if ($unsigned(span[a]) > edge_max) begin
        edge_max = $unsigned(span[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      for (int a = 0; a < 3; a++) begin
        lo_r[a] <= '0;
        hi_r[a] <= '0;
      end
    end else if (do_clear) begin
      count_r <= '0;
      for (int a = 0; a < 3; a++) begin
        lo_r[a] <= '0;
        hi_r[a] <= '0;
      end
    end else if (do_append) begin
      count_r <= count_r + CNT_W'(1);
      for (int a = 0; a < 3; a++) begin
        if ((count_r == '0) || (in_coord[a] < lo_r[a])) begin
          lo_r[a] <= in_coord[a];
        end
        if ((count_r == '0) || (in_coord[a] > hi_r[a])) begin
          hi_r[a] <= in_coord[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_append) begin
      mem[count_r[IDX_W-1:0]] <= {in_coord[2], in_coord[1], in_coord[0]};
    end
    if (do_read) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (do_read) begin
          state_nxt = S_MID;
        end
      end
      S_MID: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        state_nxt = S_DIV;
        step_nxt  = '0;
      end
      S_DIV: begin
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_WAIT;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_WAIT: begin
        if (can_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    lane_ctrl.mid_ld = (state_r == S_MID);
    lane_ctrl.d_ld   = (state_r == S_LOAD);
    lane_ctrl.step   = (state_r == S_DIV);
    merge_load       = (state_r == S_WAIT) && can_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_read) begin
      bad_r <= (idx_ext >= CMP_W'(count_r));
    end
    if (state_r == S_MID) begin
      edge_r <= edge_max;
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    vbn_lane #(
      .COORD_BITS (COORD_BITS)
    ) u_lane (
      .clk      (clk),
      .ctrl     (lane_ctrl),
      .coord    ($signed(rdata_r[g*COORD_BITS +: COORD_BITS])),
      .lo       (lo_r[g]),
      .hi       (hi_r[g]),
      .edge_len (edge_r),
      .res      (lane_res[g])
    );
  end

  vbn_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (merge_load),
    .lane_res  (lane_res),
    .zero_edge (edge_r == '0),
    .bad_index (bad_r),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/vbn_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_bbox_normalizer_defines.svh"

module vbn_checker import vbn_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic read_accept;
  logic out_stall;
  logic flagged;
  logic ok_result;
  logic zero_coords;
  logic in_range;

  assign read_accept = in_valid && in_ready && (in_data.func == FUNC_READ);
  assign out_stall   = out_valid && !out_ready;
  assign flagged     = out_valid && (out_data.status != ST_OK);
  assign ok_result   = out_valid && (out_data.status == ST_OK);
  assign zero_coords = (out_data.x_out == '0) && (out_data.y_out == '0) &&
                       (out_data.z_out == '0);
  assign in_range    = ($signed(out_data.x_out) <= 16'sd16384) &&
                       ($signed(out_data.x_out) >= -16'sd16384) &&
                       ($signed(out_data.y_out) <= 16'sd16384) &&
                       ($signed(out_data.y_out) >= -16'sd16384) &&
                       ($signed(out_data.z_out) <= 16'sd16384) &&
                       ($signed(out_data.z_out) >= -16'sd16384);

  `VBN_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_valid && in_ready), "reset did not idle")
  `VBN_ASSERT(a_flag_zeros, flagged |-> zero_coords, "flagged result carries nonzero coordinates")
  `VBN_ASSERT(a_range, ok_result |-> in_range, "normalized coordinate out of range")
  `VBN_ASSERT(a_read_busy, read_accept |=> !in_ready, "read transaction did not occupy the divider")
  `VBN_ASSERT(a_out_hold, out_stall |=> (out_valid && $stable(out_data)), "stalled result changed")

endmodule

bind vertex_bbox_normalizer vbn_checker u_vbn_checker (.*);

`default_nettype wire
